>>> hdl/pwalk_pkg.sv
// Shared types and constants for the four-level page table walker.
// Used by four_level_page_table_walker_core; no dependencies.
package pwalk_pkg;

  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int FRAME_BITS        = 40;

  localparam int IDX_W      = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W     = $clog2(TABLE_PAGES);
  localparam int ADDR_W     = PAGE_W + IDX_W;
  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ENTRY_W    = FRAME_BITS + 3;
  localparam int VA_W       = 48;
  localparam int PAGE_PORT_W = 40;
  localparam int PHYS_W     = 52;
  localparam int OFFSET_W   = 12;
  localparam int ROOT_W     = 6;
  localparam int BASE_W     = 6;
  localparam int NFREE_W    = ((PAGE_W > BASE_W) ? PAGE_W : BASE_W) + 1;

  localparam logic [BASE_W-1:0] ALLOC_BASE_RESET = BASE_W'(1);

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_MAP       = 2'd1;
  localparam logic [1:0] ACT_UNMAP     = 2'd2;

  localparam logic [1:0] LVL_TOP  = 2'd3;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  user;
    logic                  writable;
    logic                  present;
  } entry_t;

  // Table index for one level: level 3 takes bits 47..39, level 0 bits 20..12.
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd3:    idx = va[OFFSET_W + 3*IDX_W +: IDX_W];
      2'd2:    idx = va[OFFSET_W + 2*IDX_W +: IDX_W];
      2'd1:    idx = va[OFFSET_W + IDX_W +: IDX_W];
      default: idx = va[OFFSET_W +: IDX_W];
    endcase
    return idx;
  endfunction

endpackage

>>> hdl/pwalk_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pwalk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/four_level_page_table_walker_core.sv
// Four-level page table walker: the table store RAM and its walk sequencer.
// Depends on pwalk_pkg and pwalk_ram.
//
// Usage:
//   A request on the in_ channel (valid/ready) asks for a translate, a map or
//   an unmap of one 4 KiB page below the table page root_table. Each request
//   yields exactly one result on the out_ channel (valid/ready).
//   The walk reads one table entry per level through the single read port of
//   the store RAM, in a look state and a check state per level. out_valid
//   rises from the final state, and the next request can be taken once the
//   walker is back in idle; a map without new tables takes the same path.
//   Every table that a map has to create costs a zeroing sweep over its 512
//   entries through the RAM write port plus a link state to link it.
//   One request is in flight at a time; a new request is taken while the
//   previous result still waits in the output register. If the receiver
//   stalls, the walker finishes the next request and holds in its final
//   state until the output register frees up.
//   After reset the store is zeroed by a clearing pass over all 32768
//   entries (one entry per cycle); in_ready stays low during it. cfg_write_en
//   loads the first table page handed out to new tables (reset value 1); the
//   user must write it only while the block is idle; the block does not enforce this.
module four_level_page_table_walker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic [pwalk_pkg::ROOT_W-1:0]        in_root_table,
  input  logic [pwalk_pkg::VA_W-1:0]          in_virt_address,
  input  logic [pwalk_pkg::PAGE_PORT_W-1:0]   in_phys_page,
  input  logic                                in_user_access,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_present,
  output logic [pwalk_pkg::PHYS_W-1:0]        out_phys_address,
  output logic                                out_status,
  input  logic                                cfg_write_en,
  input  logic [pwalk_pkg::BASE_W-1:0]        cfg_write_data
);
  import pwalk_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_ZERO,
    S_LINK,
    S_FIN
  } state_t;

  state_t                 state_r;
  logic [ADDR_W-1:0]      cnt_r;
  logic [NFREE_W-1:0]     next_free_r;
  logic [1:0]             action_r;
  logic [VA_W-1:0]        va_r;
  logic [FRAME_BITS-1:0]  page_r;
  logic                   user_r;
  logic [PAGE_W-1:0]      tbl_r;
  logic [PAGE_W-1:0]      new_tbl_r;
  logic [1:0]             level_r;
  logic                   res_present_r;
  logic [PHYS_W-1:0]      res_phys_r;
  logic                   res_status_r;
  logic                   out_valid_r;
  logic                   out_present_r;
  logic [PHYS_W-1:0]      out_phys_r;
  logic                   out_status_r;

  logic                   ram_wr_en;
  logic [ADDR_W-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0]     ram_wr_data;
  logic                   ram_rd_en;
  logic [ENTRY_W-1:0]     ram_rd_data;

  logic [ADDR_W-1:0]      cur_addr;
  entry_t                 rd_entry;
  entry_t                 link_entry;
  entry_t                 leaf_entry;
  logic                   link_ok;
  logic                   in_fire;

  assign cur_addr = {tbl_r, level_index(va_r, level_r)};
  assign rd_entry = entry_t'(ram_rd_data);
  assign link_ok  = rd_entry.present && (rd_entry.frame < TABLE_PAGES);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    link_entry          = '0;
    link_entry.present  = 1'b1;
    link_entry.writable = 1'b1;
    link_entry.user     = 1'b1;
    link_entry.frame    = FRAME_BITS'(new_tbl_r);

    leaf_entry          = '0;
    leaf_entry.present  = 1'b1;
    leaf_entry.writable = 1'b1;
    leaf_entry.user     = user_r;
    leaf_entry.frame    = page_r;
  end

  // Store RAM port control. Reads and writes never target the same cycle,
  // so each read sees every earlier write without forwarding.
  always_comb begin
    ram_rd_en   = (state_r == S_LOOK);
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_addr;
    ram_wr_data = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cnt_r;
      end
      S_ZERO: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = {new_tbl_r, cnt_r[IDX_W-1:0]};
      end
      S_LINK: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = link_entry;
      end
      S_CHECK: begin
        if (level_r == LVL_LEAF) begin
          if (action_r == ACT_MAP) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = leaf_entry;
          end else if (action_r == ACT_UNMAP) begin
            ram_wr_en   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  pwalk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cur_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      next_free_r <= NFREE_W'(ALLOC_BASE_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            action_r      <= in_action;
            va_r          <= in_virt_address;
            page_r        <= in_phys_page[FRAME_BITS-1:0];
            user_r        <= in_user_access;
            tbl_r         <= PAGE_W'(in_root_table);
            level_r       <= LVL_TOP;
            res_present_r <= 1'b0;
            res_phys_r    <= '0;
            res_status_r  <= 1'b0;
            if (in_action != ACT_TRANSLATE && in_action != ACT_MAP &&
                in_action != ACT_UNMAP) begin
              state_r <= S_FIN;
            end else if (in_root_table >= TABLE_PAGES) begin
              // A root outside the store is a missing path; map fails on it.
              res_status_r <= (in_action == ACT_MAP);
              state_r      <= S_FIN;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end

        S_LOOK: begin
          state_r <= S_CHECK;
        end

        S_CHECK: begin
          if (level_r == LVL_LEAF) begin
            if (action_r == ACT_TRANSLATE && rd_entry.present) begin
              res_present_r <= 1'b1;
              res_phys_r    <= PHYS_W'({rd_entry.frame, va_r[OFFSET_W-1:0]});
            end
            state_r <= S_FIN;
          end else if (link_ok) begin
            tbl_r   <= rd_entry.frame[PAGE_W-1:0];
            level_r <= level_r - 1'b1;
            state_r <= S_LOOK;
          end else if (action_r != ACT_MAP) begin
            state_r <= S_FIN;
          end else if (next_free_r >= TABLE_PAGES) begin
            res_status_r <= 1'b1;
            state_r      <= S_FIN;
          end else begin
            // Take a fresh table, zero it, then link it into this level.
            new_tbl_r   <= next_free_r[PAGE_W-1:0];
            next_free_r <= next_free_r + 1'b1;
            cnt_r       <= '0;
            state_r     <= S_ZERO;
          end
        end

        S_ZERO: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r[IDX_W-1:0]) begin
            state_r <= S_LINK;
          end
        end

        S_LINK: begin
          tbl_r   <= new_tbl_r;
          level_r <= level_r - 1'b1;
          state_r <= S_LOOK;
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_present_r <= res_present_r;
            out_phys_r    <= res_phys_r;
            out_status_r  <= res_status_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_write_en) begin
        next_free_r <= NFREE_W'(cfg_write_data);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_present      = out_present_r;
  assign out_phys_address = out_phys_r;
  assign out_status       = out_status_r;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for four_level_page_table_walker_core: directed requests, then
// random phases at several alloc_base settings, checked against a model of the table store.
// Depends on pwalk_pkg and the walker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwalk_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [1:0]             action;
    logic [ROOT_W-1:0]      root;
    logic [VA_W-1:0]        va;
    logic [PAGE_PORT_W-1:0] page;
    logic                   user;
  } walk_req_t;

  typedef struct packed {
    logic              present;
    logic [PHYS_W-1:0] phys;
    logic              status;
  } walk_out_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_PREDICT, STEP_FIXED} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    walk_req_t  req;
    walk_out_t  known;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_action;
  logic [ROOT_W-1:0] in_root_table;
  logic [VA_W-1:0] in_virt_address;
  logic [PAGE_PORT_W-1:0] in_phys_page;
  logic in_user_access;
  logic out_valid;
  logic out_ready;
  logic out_present;
  logic [PHYS_W-1:0] out_phys_address;
  logic out_status;
  logic cfg_write_en;
  logic [BASE_W-1:0] cfg_write_data;

  // Shadow of the table store and the bump pointer, updated as requests are accepted.
  entry_t table_copy [STORE_DEPTH];
  logic [NFREE_W-1:0] next_table;

  walk_out_t results_due [$];
  plan_row_t plan [$];
  int requests_sent = 0;
  int results_checked = 0;
  int bad_results = 0;
  int cycle_count = 0;

  four_level_page_table_walker_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_root_table    (in_root_table),
    .in_virt_address  (in_virt_address),
    .in_phys_page     (in_phys_page),
    .in_user_access   (in_user_access),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_present      (out_present),
    .out_phys_address (out_phys_address),
    .out_status       (out_status),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_level_page_table_walker_core verification failed");
      $finish;
    end
  end

  function automatic int unsigned slot_of(input int unsigned tbl,
                                          input logic [VA_W-1:0] va, input int lvl);
    return tbl * ENTRIES_PER_TABLE + int'(va[OFFSET_W + IDX_W*lvl +: IDX_W]);
  endfunction

  // Applies one request to the shadow store and returns the result it must produce.
  // Levels run 3 (top) down to 0 (leaf).
  function automatic walk_out_t page_walk(input walk_req_t r);
    walk_out_t res;
    entry_t e;
    int unsigned tbl;
    int unsigned slot;
    int lvl;
    int k;
    bit ok;
    res = '0;
    tbl = r.root;
    ok = 1'b1;
    if (r.action == ACT_TRANSLATE || r.action == ACT_UNMAP) begin
      for (lvl = 3; lvl >= 1 && ok; lvl--) begin
        e = table_copy[slot_of(tbl, r.va, lvl)];
        // A link whose frame is past the store counts as missing.
        if (e.present && e.frame < TABLE_PAGES) tbl = e.frame[PAGE_W-1:0];
        else ok = 1'b0;
      end
      slot = slot_of(tbl, r.va, 0);
      if (ok && r.action == ACT_UNMAP) begin
        table_copy[slot] = '0;
      end else if (ok && table_copy[slot].present) begin
        res.present = 1'b1;
        res.phys = {table_copy[slot].frame, r.va[OFFSET_W-1:0]};
      end
    end else if (r.action == ACT_MAP) begin
      for (lvl = 3; lvl >= 1 && ok; lvl--) begin
        slot = slot_of(tbl, r.va, lvl);
        e = table_copy[slot];
        if (!(e.present && e.frame < TABLE_PAGES)) begin
          if (next_table >= TABLE_PAGES) begin
            ok = 1'b0;
          end else begin
            for (k = 0; k < ENTRIES_PER_TABLE; k++)
              table_copy[next_table * ENTRIES_PER_TABLE + k] = '0;
            e = '0;
            e.present = 1'b1;
            e.writable = 1'b1;
            e.user = 1'b1;
            e.frame = FRAME_BITS'(next_table);
            table_copy[slot] = e;
            next_table++;
          end
        end
        if (ok) tbl = e.frame[PAGE_W-1:0];
      end
      if (ok) begin
        e.present = 1'b1;
        e.writable = 1'b1;
        e.user = r.user;
        e.frame = r.page;
        table_copy[slot_of(tbl, r.va, 0)] = e;
      end else begin
        res.status = 1'b1;
      end
    end
    return res;
  endfunction

  // For a configuration row the new alloc_base travels in the root field.
  function automatic void plan_add(input step_kind_t kind, input logic [1:0] action,
                                   input logic [ROOT_W-1:0] root, input logic [VA_W-1:0] va,
                                   input logic [PAGE_PORT_W-1:0] page, input logic user,
                                   input walk_out_t known);
    plan_row_t row;
    row.kind = kind;
    row.req.action = action;
    row.req.root = root;
    row.req.va = va;
    row.req.page = page;
    row.req.user = user;
    row.known = known;
    plan.push_back(row);
  endfunction

  task automatic send_request(input walk_req_t r, input bit known_given,
                              input walk_out_t known);
    int gap;
    int pick;
    walk_out_t predicted;
    pick = $urandom_range(0, 99);
    if ((requests_sent / 40) % 4 == 0) gap = 0;
    else if (pick < 50) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    in_root_table <= r.root;
    in_virt_address <= r.va;
    in_phys_page <= r.page;
    in_user_access <= r.user;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = page_walk(r);
    results_due.push_back(known_given ? known : predicted);
    requests_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_alloc_base(input logic [BASE_W-1:0] value);
    wait_results_done();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    next_table = NFREE_W'(value);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int pick;
    bit hold_done;
    walk_out_t got;
    walk_out_t want;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.present = out_present;
        got.phys = out_phys_address;
        got.status = out_status;
        if (results_due.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result: present %0b phys %h status %0b",
                     got.present, got.phys, got.status);
        end else begin
          want = results_due.pop_front();
          if (got.present !== want.present || got.phys !== want.phys ||
              got.status !== want.status) begin
            bad_results++;
            if (bad_results <= 10)
              $display("result %0d: expected present %0b phys %h status %0b, got %0b %h %0b",
                       results_checked, want.present, want.phys, want.status,
                       got.present, got.phys, got.status);
          end
        end
        results_checked++;
      end
      // One long hold-off so the walker fills up and stalls new requests.
      if (!hold_done && results_checked >= 150) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (rst_n !== 1'b1) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ((cycle_count / 1500) % 4 == 0) begin
        out_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : request_source
    int p;
    int i;
    int l;
    int k;
    int pick;
    int counted;
    walk_req_t r;
    logic [BASE_W-1:0] phase_base [4];
    logic [ROOT_W-1:0] roots [3];
    logic [IDX_W-1:0] idx_pool [4][4];
    walk_req_t recent [$];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_TRANSLATE;
    in_root_table = '0;
    in_virt_address = '0;
    in_phys_page = '0;
    in_user_access = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    foreach (table_copy[i]) table_copy[i] = '0;
    next_table = NFREE_W'(ALLOC_BASE_RESET);

    // Empty store: nothing translates, unknown action and unmap give zeros.
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd0, 48'h0, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd63, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b1, '0);
    plan_add(STEP_FIXED, ACT_NONE, 6'd63, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, '0);
    plan_add(STEP_FIXED, ACT_UNMAP, 6'd0, 48'h0, 40'h0, 1'b0, '0);
    // Two maps at the address extremes build tables 1..3 and 4..6.
    plan_add(STEP_FIXED, ACT_MAP, 6'd0, 48'h0, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd0, 48'h0000_0000_0ABC, 40'h0, 1'b0,
             '{1'b1, 52'hABC, 1'b0});
    plan_add(STEP_FIXED, ACT_MAP, 6'd0, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, '0);
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd0, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0,
             '{1'b1, 52'hF_FFFF_FFFF_FFFF, 1'b0});
    // Remap over a present leaf, then alternating bit patterns.
    plan_add(STEP_PREDICT, ACT_MAP, 6'd0, 48'h0, 40'h12_3456_789A, 1'b1, '0);
    plan_add(STEP_PREDICT, ACT_TRANSLATE, 6'd0, 48'h0000_0000_0123, 40'h0, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_MAP, 6'd0, 48'h5555_5555_5555, 40'hAA_AAAA_AAAA, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_TRANSLATE, 6'd0, 48'h5555_5555_5AAA, 40'h0, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_MAP, 6'd2, 48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 1'b1, '0);
    plan_add(STEP_PREDICT, ACT_TRANSLATE, 6'd2, 48'hAAAA_AAAA_AAAA, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_UNMAP, 6'd0, 48'h0, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd0, 48'h0000_0000_0FFF, 40'h0, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_TRANSLATE, 6'd0, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0, '0);
    // Table 6 used as a root: its top entry holds a frame past the store, a bad link.
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd6, 48'hFF80_0000_0000, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_UNMAP, 6'd6, 48'hFF80_0000_0000, 40'h0, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_MAP, 6'd6, 48'hFF80_0000_0000, 40'h1, 1'b0, '0);
    plan_add(STEP_PREDICT, ACT_TRANSLATE, 6'd0, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0, '0);
    // Only one table page left: a map that needs three runs out.
    plan_add(STEP_CFG, ACT_NONE, 6'd63, 48'h0, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_MAP, 6'd0, 48'h0280_0000_0000, 40'h7, 1'b1,
             '{1'b0, 52'h0, 1'b1});
    plan_add(STEP_FIXED, ACT_TRANSLATE, 6'd0, 48'h0280_0000_0000, 40'h0, 1'b0, '0);
    plan_add(STEP_FIXED, ACT_MAP, 6'd0, 48'h0280_0000_0000, 40'h7, 1'b1,
             '{1'b0, 52'h0, 1'b1});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) write_alloc_base(plan[i].req.root);
      else send_request(plan[i].req, plan[i].kind == STEP_FIXED, plan[i].known);
    end

    phase_base[0] = BASE_W'(1);
    phase_base[1] = BASE_W'($urandom_range(2, 62));
    phase_base[2] = BASE_W'(63);
    phase_base[3] = BASE_W'($urandom_range(1, 63));
    for (p = 0; p < 4; p++) begin
      write_alloc_base(phase_base[p]);
      for (i = 0; i < 3; i++) roots[i] = ROOT_W'($urandom_range(0, phase_base[p] - 1));
      for (l = 0; l < 4; l++) begin
        idx_pool[l][0] = '0;
        idx_pool[l][1] = '1;
        idx_pool[l][2] = IDX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
        idx_pool[l][3] = IDX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
      end
      recent.delete();
      counted = 0;
      while (counted < 170) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) r.action = ACT_MAP;
        else if (pick < 75) r.action = ACT_TRANSLATE;
        else if (pick < 93) r.action = ACT_UNMAP;
        else r.action = ACT_NONE;
        if ($urandom_range(0, 99) < 85) r.root = roots[$urandom_range(0, 2)];
        else r.root = ROOT_W'($urandom_range(0, 63));
        // Mostly addresses built from a few indexes per level so paths share tables.
        if ($urandom_range(0, 99) < 75)
          r.va = {idx_pool[3][$urandom_range(0, 3)], idx_pool[2][$urandom_range(0, 3)],
                  idx_pool[1][$urandom_range(0, 3)], idx_pool[0][$urandom_range(0, 3)],
                  OFFSET_W'($urandom)};
        else
          r.va = VA_W'({$urandom, $urandom});
        pick = (r.action == ACT_MAP) ? 25 : 60;
        if (recent.size() != 0 && $urandom_range(0, 99) < pick) begin
          k = $urandom_range(0, recent.size() - 1);
          r.root = recent[k].root;
          r.va = {recent[k].va[VA_W-1:OFFSET_W], OFFSET_W'($urandom)};
        end
        r.page = PAGE_PORT_W'({$urandom, $urandom});
        r.user = 1'($urandom);
        send_request(r, 1'b0, '0);
        if (r.action == ACT_MAP) begin
          recent.push_back(r);
          if (recent.size() > 24) void'(recent.pop_front());
        end
        if (r.action != ACT_NONE) counted++;
      end
    end

    wait_results_done();
    repeat (20) @(posedge clk);
    if (bad_results == 0) begin
      $display("four_level_page_table_walker_core verification clean");
    end else begin
      $display("four_level_page_table_walker_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pwalk_pkg.sv
hdl/pwalk_ram.sv
hdl/four_level_page_table_walker_core.sv
tb/sv/tb.sv
